### src/normalized_midpoint_3d_unit_defines.svh
// Assertion macros for the normalized midpoint unit.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef NORMALIZED_MIDPOINT_3D_UNIT_DEFINES_SVH
`define NORMALIZED_MIDPOINT_3D_UNIT_DEFINES_SVH

// same-cycle implication
`define NMID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NMID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/nmid_pkg.sv
// Types, widths and the root-search step for the normalized midpoint unit.
// No dependencies; imported by nmid_skid, normalized_midpoint_3d_unit and nmid_result_checker.
`timescale 1ns / 1ps

package nmid_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgW   = 62;
  localparam int unsigned SqW    = 64;
  localparam int unsigned RemW   = 130;
  localparam int unsigned QW     = 98;
  localparam int unsigned RootW  = 31;
  localparam int unsigned Steps  = 31;
  localparam int unsigned Lanes  = 3;

  typedef struct packed {
    logic [RootW-1:0]       r;
    logic signed [RemW-1:0] rem;
    logic signed [QW-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic                          degen;
    logic [Lanes-1:0][CoordW-1:0]  m;
    logic [SqW-1:0]                s;
    lane_t [Lanes-1:0]             ln;
  } stg_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              degen;
  } res_t;

  // Try one root bit: keep rem = M - (2r-1)^2 S and q = (2r-1) S.
  function automatic lane_t nmid_step_f(lane_t cur, logic [SqW-1:0] s, int unsigned b);
    logic signed [RemW-1:0] q_ext;
    logic signed [RemW-1:0] s_ext;
    logic signed [RemW-1:0] cand;
    lane_t                  nxt;
    q_ext = RemW'(cur.q);
    s_ext = $signed({{(RemW-SqW){1'b0}}, s});
    cand  = cur.rem - (q_ext <<< (b + 2)) - (s_ext <<< (2 * b + 2));
    nxt   = cur;
    if (!cand[RemW-1]) begin
      nxt.rem = cand;
      nxt.r   = cur.r | (RootW'(1) << b);
      nxt.q   = cur.q + $signed({{(QW-SqW){1'b0}}, s} << (b + 1));
    end
    return nxt;
  endfunction

endpackage

### src/normalized_midpoint_3d_unit.sv
// Top level: midpoint of two Q1.30 points scaled onto the unit sphere.
// Depends on nmid_pkg, nmid_skid and normalized_midpoint_3d_unit_defines.svh.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   input    | in_valid_i / in_stall_o    | first_{x,y,z}_i, second_{x,y,z}_i
//   result   | out_valid_o / out_stall_i  | unit_{x,y,z}_o, degenerate_o
//   config   | cfg_valid_i / cfg_ready_o  | cfg_min_squared_length_i
//
// One item per cycle unless the skid entry is full; stages: midpoint, squares, sum,
// setup, 31 root-search stages (one result bit each), output register.
// Reset clears all valid bits and sets the threshold to 1.
// A stalled result parks one item in a skid entry; the pipeline holds while it is full.
`timescale 1ns / 1ps
`include "normalized_midpoint_3d_unit_defines.svh"

module normalized_midpoint_3d_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] first_z_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  input  logic [31:0] second_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] unit_x_o,
  output logic [31:0] unit_y_o,
  output logic [31:0] unit_z_o,
  output logic        degenerate_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [61:0] cfg_min_squared_length_i
);
  import nmid_pkg::*;

  logic                         en, full;
  logic [CfgW-1:0]              min_q;
  logic [Lanes-1:0][CoordW-1:0] a_in, b_in;
  logic                         va_q, vb_q, vc_q;
  logic [Lanes-1:0][CoordW-1:0] ma_q, mb_q, mc_q;
  logic [Lanes-1:0][SqW-1:0]    sqb_q, sqc_q;
  logic [SqW-1:0]               sc_q;
  logic [Steps:0]               pv_q;
  stg_t                         p_q [Steps+1];
  stg_t                         setup_d;
  res_t                         res_d, res_q;

  assign en          = !full;
  assign in_stall_o  = full;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= CfgW'(1);
    end else if (cfg_valid_i) begin
      min_q <= cfg_min_squared_length_i;
    end
  end

  assign a_in = {first_z_i, first_y_i, first_x_i};
  assign b_in = {second_z_i, second_y_i, second_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      pv_q <= '0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      pv_q <= {pv_q[Steps-1:0], vc_q};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [CoordW:0]   sum;
    logic [CoordW-1:0] mag;
    if (en) begin
      for (int i = 0; i < Lanes; i++) begin
        sum      = {a_in[i][CoordW-1], a_in[i]} + {b_in[i][CoordW-1], b_in[i]};
        ma_q[i] <= sum[CoordW:1];
        mag      = ma_q[i][CoordW-1] ? CoordW'(-ma_q[i]) : ma_q[i];
        sqb_q[i] <= {32'b0, mag} * {32'b0, mag};
      end
      mb_q  <= ma_q;
      mc_q  <= mb_q;
      sqc_q <= sqb_q;
      sc_q  <= sqb_q[0] + sqb_q[1] + sqb_q[2];
    end
  end

  always_comb begin
    setup_d.degen = (sc_q == '0) || (sc_q < {2'b0, min_q});
    setup_d.m     = mc_q;
    setup_d.s     = sc_q;
    for (int i = 0; i < Lanes; i++) begin
      setup_d.ln[i].r   = '0;
      setup_d.ln[i].rem = $signed({4'b0, sqc_q[i], 62'b0}) - $signed({66'b0, sc_q});
      setup_d.ln[i].q   = -$signed({34'b0, sc_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= setup_d;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[k+1].degen <= p_q[k].degen;
        p_q[k+1].m     <= p_q[k].m;
        p_q[k+1].s     <= p_q[k].s;
        for (int i = 0; i < Lanes; i++) begin
          p_q[k+1].ln[i] <= nmid_step_f(p_q[k].ln[i], p_q[k].s, Steps - 1 - k);
        end
      end
    end
  end

  always_comb begin
    logic [Lanes-1:0][CoordW-1:0] u;
    for (int i = 0; i < Lanes; i++) begin
      if (p_q[Steps].degen) begin
        u[i] = p_q[Steps].m[i];
      end else if (p_q[Steps].m[i][CoordW-1]) begin
        u[i] = -{1'b0, p_q[Steps].ln[i].r};
      end else begin
        u[i] = {1'b0, p_q[Steps].ln[i].r};
      end
    end
    res_d.x     = u[0];
    res_d.y     = u[1];
    res_d.z     = u[2];
    res_d.degen = p_q[Steps].degen;
  end

  nmid_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pv_q[Steps] & en),
    .in_data_i   (res_d),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_q)
  );

  assign unit_x_o     = res_q.x;
  assign unit_y_o     = res_q.y;
  assign unit_z_o     = res_q.z;
  assign degenerate_o = res_q.degen;

  `NMID_ASSERT_NOW(a_skid_needs_out, in_stall_o, out_valid_o, "skid full without output item")
  `NMID_ASSERT_NOW(a_unit_range, out_valid_o && !degenerate_o,
    ($signed(unit_x_o) <= 32'sd1073741824) && ($signed(unit_x_o) >= -32'sd1073741824) &&
    ($signed(unit_y_o) <= 32'sd1073741824) && ($signed(unit_y_o) >= -32'sd1073741824) &&
    ($signed(unit_z_o) <= 32'sd1073741824) && ($signed(unit_z_o) >= -32'sd1073741824),
    "normalized coordinate out of range")
  `NMID_ASSERT_NOW(a_skid_fill, $rose(in_stall_o), $past(out_valid_o && out_stall_i),
    "skid filled without a stalled output")

endmodule

### src/nmid_skid.sv
// Output register plus one skid entry for the normalized midpoint unit.
// Depends on nmid_pkg for the result type.
`timescale 1ns / 1ps

module nmid_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  nmid_pkg::res_t in_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output nmid_pkg::res_t out_data_o
);
  import nmid_pkg::*;

  logic out_v_q, skid_v_q, load_out;
  res_t out_q, skid_q;

  assign load_out = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q  <= skid_v_q | in_valid_i;
      skid_v_q <= 1'b0;
    end else if (in_valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : in_data_i;
    end else if (in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### sim/nmid_result_checker.sv
// Result checker for normalized_midpoint_3d_unit: tracks the threshold, predicts each result.
// Depends on nmid_pkg (res_t); instantiated beside the block by tb_normalized_midpoint_3d_unit.
`timescale 1ns / 1ps

module nmid_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] first_z_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  input  logic [31:0] second_z_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] unit_x_i,
  input  logic [31:0] unit_y_i,
  input  logic [31:0] unit_z_i,
  input  logic        degenerate_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [61:0] cfg_min_squared_length_i,
  output int          fail_count_o,
  output int          pending_o
);
  import nmid_pkg::*;

  logic [61:0] min_sq_len;
  res_t        expected_q[$];
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic [31:0] unit_coord(logic [31:0] mag, logic neg, logic [63:0] s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [63:0]  d;
    logic [31:0]  r;
    logic [31:0]  c;
    rhs = 128'(64'(mag) * 64'(mag)) << 62;
    r   = '0;
    for (int b = 30; b >= 0; b--) begin
      c   = r | (32'd1 << b);
      d   = 2 * 64'(c) - 1;
      lhs = 128'(d * d) * 128'(s);
      if (lhs <= rhs) r = c;
    end
    return neg ? -r : r;
  endfunction

  function automatic res_t predict_unit_midpoint(logic [31:0] ax, logic [31:0] ay,
                                                 logic [31:0] az, logic [31:0] bx,
                                                 logic [31:0] by, logic [31:0] bz);
    logic [32:0] sum;
    logic [31:0] m[3];
    logic [31:0] mag[3];
    logic [31:0] a[3];
    logic [31:0] b[3];
    logic [63:0] s;
    res_t        res;
    a = '{ax, ay, az};
    b = '{bx, by, bz};
    s = '0;
    for (int i = 0; i < 3; i++) begin
      sum    = {a[i][31], a[i]} + {b[i][31], b[i]};
      m[i]   = sum[32:1];
      mag[i] = m[i][31] ? -m[i] : m[i];
      s      = s + 64'(mag[i]) * 64'(mag[i]);
    end
    if (s == 0 || s < 64'(min_sq_len)) begin
      res = '{x: m[0], y: m[1], z: m[2], degen: 1'b1};
    end else begin
      res.x     = unit_coord(mag[0], m[0][31], s);
      res.y     = unit_coord(mag[1], m[1][31], s);
      res.z     = unit_coord(mag[2], m[2][31], s);
      res.degen = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      min_sq_len = 62'd1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) min_sq_len = cfg_min_squared_length_i;
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_unit_midpoint(first_x_i, first_y_i, first_z_i,
                                                   second_x_i, second_y_i, second_z_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected item on result channel", $realtime);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (unit_x_i !== want.x) report_mismatch("unit_x", unit_x_i, want.x);
          if (unit_y_i !== want.y) report_mismatch("unit_y", unit_y_i, want.y);
          if (unit_z_i !== want.z) report_mismatch("unit_z", unit_z_i, want.z);
          if (degenerate_i !== want.degen)
            report_mismatch("degenerate", 32'(degenerate_i), 32'(want.degen));
        end
      end
    end
  end

endmodule

### sim/tb_normalized_midpoint_3d_unit.sv
// Testbench top for normalized_midpoint_3d_unit: drives points, stalls and threshold writes.
// Depends on the block, nmid_pkg and nmid_result_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb_normalized_midpoint_3d_unit;

  localparam int          WatchdogLimit = 20000;
  localparam int          IdlePct       = 38;
  localparam longint      MaxThr        = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] PosOne        = 32'h4000_0000;
  localparam logic [31:0] NegOne        = 32'hC000_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] ux, uy, uz;
  logic        degen;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [61:0] cfg_thr = '0;
  int          fail_count;
  int          pending;
  bit          no_idle = 1'b0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  normalized_midpoint_3d_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .first_x_i(ax), .first_y_i(ay), .first_z_i(az),
    .second_x_i(bx), .second_y_i(by), .second_z_i(bz),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .unit_x_o(ux), .unit_y_o(uy), .unit_z_o(uz), .degenerate_o(degen),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_min_squared_length_i(cfg_thr)
  );

  nmid_result_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .first_x_i(ax), .first_y_i(ay), .first_z_i(az),
    .second_x_i(bx), .second_y_i(by), .second_z_i(bz),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .unit_x_i(ux), .unit_y_i(uy), .unit_z_i(uz), .degenerate_i(degen),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_min_squared_length_i(cfg_thr),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall unless no_idle is set, one long hold-off once the 300th input item is taken
  always @(posedge clk) begin
    int rx_items;
    int hold_left;
    if (in_valid && !in_stall) begin
      rx_items++;
      if (rx_items == 300) hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_points(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                             logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
    bit taken;
    if (!no_idle) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    ax <= x0; ay <= y0; az <= z0; bx <= x1; by <= y1; bz <= z1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_threshold(logic [61:0] thr);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_thr   <= thr;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
      1: return $urandom();
      2: return 32'($urandom_range(32'h1_0000) - 32'h8000);
      default: return ($urandom_range(1)) ? PosOne : NegOne;
    endcase
  endfunction

  task automatic send_random(int n);
    logic [31:0] p[6];
    int          kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(3);
      foreach (p[j]) p[j] = rand_coord(($urandom_range(9) == 0) ? $urandom_range(3) : kind);
      if ($urandom_range(7) == 0) begin
        // near-opposite points give a tiny midpoint
        p[3] = -p[0] + $urandom_range(2);
        p[4] = -p[1];
        p[5] = -p[2] - $urandom_range(1);
      end
      send_points(p[0], p[1], p[2], p[3], p[4], p[5]);
    end
  endtask

  initial begin
    logic [61:0] thr_set[5];
    thr_set = '{62'd1, 62'd0, 62'(MaxThr), 62'h100_0000_0000,
                62'({$urandom(), $urandom()}) & 62'(MaxThr)};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold first
    send_points('0, '0, '0, '0, '0, '0);
    send_points(PosOne, PosOne, PosOne, PosOne, PosOne, PosOne);
    send_points(NegOne, NegOne, NegOne, NegOne, NegOne, NegOne);
    send_points(PosOne, '0, '0, PosOne, '0, '0);
    send_points('0, NegOne, '0, '0, NegOne, '0);
    send_points('0, '0, PosOne, '0, '0, '0);
    send_points(PosOne, '0, '0, '0, PosOne, '0);
    send_points(PosOne, PosOne, '0, NegOne, NegOne, '0);
    send_points(32'd1, '0, '0, '0, '0, '0);
    send_points(32'd1, '0, '0, 32'd1, '0, '0);
    send_points(32'hFFFF_FFFF, '0, '0, '0, '0, '0);
    send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_points(32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA);
    send_points(32'd3, 32'hFFFF_FFFD, 32'd5, 32'd2, 32'hFFFF_FFFE, 32'd6);
    send_points(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, '0, '0, '0);
    send_points(32'd12345, 32'hFFFF_0000, 32'd1, 32'd1, 32'd7, 32'hFFFF_FFFF);
    drain();

    foreach (thr_set[k]) begin
      write_threshold(thr_set[k]);
      if (k == 1) send_points('0, '0, '0, 32'd1, 32'hFFFF_FFFF, '0);
      if (k == 2) begin
        send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_points(PosOne, PosOne, '0, PosOne, PosOne, '0);
        no_idle = 1'b1;
        send_random(150);
        no_idle = 1'b0;
        send_random(50);
      end else begin
        send_random(200);
      end
      drain();
    end

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/nmid_pkg.sv
src/nmid_skid.sv
src/normalized_midpoint_3d_unit.sv
sim/nmid_result_checker.sv
sim/tb_normalized_midpoint_3d_unit.sv
